// ===== hw/rtl/cbpm_pkg.sv =====
package cbpm_pkg;

  // fraction bits of the internal unit-range channel value
  localparam int FRAC_BITS = 16;
  localparam int XW        = FRAC_BITS + 1;        // channel value, 0 .. 1.0
  localparam int CW        = 16;                   // signed Q1.14 coefficient
  localparam int WW        = FRAC_BITS + 2;        // signed step weight
  localparam int PW        = CW + WW;              // coefficient x weight
  localparam int L2W       = FRAC_BITS + 2;        // twice the lightness
  localparam int DFW       = FRAC_BITS + 3;        // signed 2c - max - min
  localparam int NW        = 2 * FRAC_BITS + 4;    // dividend
  localparam int DENW      = FRAC_BITS + 2;        // divisor
  localparam int QW        = FRAC_BITS + 2;        // quotient bits
  localparam int MAP_LAT   = 7;
  localparam int LVW       = 48;

  localparam logic [XW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef logic [XW-1:0] fix_t;

  typedef enum logic [1:0] {
    REG_RED   = 2'd0,
    REG_GREEN = 2'd1,
    REG_BLUE  = 2'd2,
    REG_KEEP  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [NW-1:0]   rem;
    logic [DENW-1:0] den;
  } div_in_t;

endpackage

// ===== hw/rtl/cbpm_map.sv =====
module cbpm_map (
  input  logic                        clk,
  input  logic                        en,
  input  logic [7:0]                  v,
  input  logic [cbpm_pkg::LVW-1:0]    levels,
  output cbpm_pkg::fix_t              x_orig,
  output cbpm_pkg::fix_t              x_map
);

  localparam int F   = cbpm_pkg::FRAC_BITS;
  localparam int XW  = cbpm_pkg::XW;
  localparam int PW  = cbpm_pkg::PW;
  localparam int CW  = cbpm_pkg::CW;
  localparam logic signed [PW-1:0] RND = PW'(1 << 13);

  // constant tables indexed by the 8-bit channel value
  logic [XW-1:0] x_rom   [256];
  logic [F-1:0]  low_rom [256];
  logic [F-1:0]  mid_rom [256];

  for (genvar gv = 0; gv < 256; gv++) begin : g_rom
    localparam longint V  = gv;
    localparam longint XV = (2 * (V << F) + 255) / 510;
    localparam longint LD = 1000 * V + 4080000;
    localparam longint LV = (2 * ((1075 * V + 306000) << F) + LD) / (2 * LD);
    localparam longint DV = 2 * V - 255;
    localparam longint MV = (2 * ((667 * (260100 - DV * DV)) << F) + 260100000)
                            / 520200000;
    assign x_rom[gv]   = XW'(XV);
    assign low_rom[gv] = F'(LV);
    assign mid_rom[gv] = F'(MV);
  end

  function automatic cbpm_pkg::fix_t step_add(cbpm_pkg::fix_t x,
                                               logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = $signed(PW'(x)) + ((p + RND) >>> 14);
    if (s < 0) return '0;
    if (s > $signed(PW'(cbpm_pkg::ONE))) return cbpm_pkg::ONE;
    return s[XW-1:0];
  endfunction

  logic signed [CW-1:0] cs, cm, ch;
  assign cs = $signed(levels[15:0]);
  assign cm = $signed(levels[31:16]);
  assign ch = $signed(levels[47:32]);

  logic [XW-1:0] low_w;
  assign low_w = XW'(low_rom[v]);

  logic [XW-1:0]        xa, xb, xc, xd, xe, xf, xg;
  logic [XW-1:0]        wsa, wma, wmb, wmc, wha, whb, whc, whd, whe;
  logic signed [PW-1:0] pb, pd, pf;
  logic [XW-1:0]        xo [cbpm_pkg::MAP_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      xa  <= x_rom[v];
      wsa <= (cs > 0) ? cbpm_pkg::ONE + low_w : cbpm_pkg::ONE - low_w;
      wma <= XW'(mid_rom[v]);
      wha <= (ch > 0) ? cbpm_pkg::ONE - low_w : cbpm_pkg::ONE + low_w;

      pb  <= cs * $signed({1'b0, wsa});
      xb  <= xa;
      wmb <= wma;
      whb <= wha;

      xc  <= step_add(xb, pb);
      wmc <= wmb;
      whc <= whb;

      pd  <= cm * $signed({1'b0, wmc});
      xd  <= xc;
      whd <= whc;

      xe  <= step_add(xd, pd);
      whe <= whd;

      pf  <= ch * $signed({1'b0, whe});
      xf  <= xe;

      xg  <= step_add(xf, pf);

      xo[0] <= x_rom[v];
      for (int i = 1; i < cbpm_pkg::MAP_LAT; i++) xo[i] <= xo[i-1];
    end
  end

  assign x_orig = xo[cbpm_pkg::MAP_LAT-1];
  assign x_map  = xg;

endmodule

// ===== hw/rtl/cbpm_div.sv =====
module cbpm_div (
  input  logic                        clk,
  input  logic                        en,
  input  cbpm_pkg::div_in_t           din,
  output logic [cbpm_pkg::QW-1:0]     quot
);

  localparam int NW   = cbpm_pkg::NW;
  localparam int DENW = cbpm_pkg::DENW;
  localparam int QW   = cbpm_pkg::QW;

  // one quotient bit per stage, most significant first
  logic [NW-1:0]   rem [QW];
  logic [DENW-1:0] den [QW];
  logic [QW-1:0]   q   [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int K = QW - 1 - s;
    logic [NW-1:0]   cur_rem;
    logic [DENW-1:0] cur_den;
    logic [QW-1:0]   cur_q;
    logic [NW-1:0]   sh;

    if (s == 0) begin : g_first
      assign cur_rem = din.rem;
      assign cur_den = din.den;
      assign cur_q   = '0;
    end else begin : g_next
      assign cur_rem = rem[s-1];
      assign cur_den = den[s-1];
      assign cur_q   = q[s-1];
    end

    assign sh = NW'(cur_den) << K;

    always_ff @(posedge clk) begin
      if (en) begin
        den[s] <= cur_den;
        if (cur_rem >= sh) begin
          rem[s] <= cur_rem - sh;
          q[s]   <= cur_q | (QW'(1) << K);
        end else begin
          rem[s] <= cur_rem;
          q[s]   <= cur_q;
        end
      end
    end
  end

  assign quot = q[QW-1];

endmodule

// ===== hw/rtl/color_balance_pixel_map.sv =====
// throughput: one pixel per cycle; every stage is a register, the divider gives one
//   quotient bit per stage, and the whole pipe advances whenever the output register is free
// reset: synchronous, clears all valid bits and the level registers (all coefficients zero,
//   lightness keeping off); payload registers are not reset
module color_balance_pixel_map (
  input  logic        clk,
  input  logic        rst,
  // pixel in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // red, green, blue, alpha
  input  logic        s_axis_tlast,   // end_of_run
  // pixel out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // red_out, green_out, blue_out, alpha_out
  output logic        m_axis_tlast,   // end_out
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  localparam int F    = cbpm_pkg::FRAC_BITS;
  localparam int XW   = cbpm_pkg::XW;
  localparam int L2W  = cbpm_pkg::L2W;
  localparam int DFW  = cbpm_pkg::DFW;
  localparam int NW   = cbpm_pkg::NW;
  localparam int DENW = cbpm_pkg::DENW;
  localparam int QW   = cbpm_pkg::QW;
  localparam int ML   = cbpm_pkg::MAP_LAT;
  localparam int LAT  = ML + 6 + QW;      // stage count including output register
  localparam int BD   = LAT - 1 - ML;     // bypass delay for the mapped values

  localparam logic [L2W-1:0] ONE2 = L2W'(cbpm_pkg::ONE);

  // ---------------------------------------------------------------- config
  logic [47:0] red_levels, green_levels, blue_levels;
  logic        keep_lightness;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_levels     <= '0;
      green_levels   <= '0;
      blue_levels    <= '0;
      keep_lightness <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cbpm_pkg::reg_idx_t'(cfg_index))
        cbpm_pkg::REG_RED:   red_levels     <= cfg_data;
        cbpm_pkg::REG_GREEN: green_levels   <= cfg_data;
        cbpm_pkg::REG_BLUE:  blue_levels    <= cfg_data;
        cbpm_pkg::REG_KEEP:  keep_lightness <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- pipe control
  // the whole pipe moves together; it only holds while the output beat waits
  logic           en;
  logic [LAT-1:0] vld;

  assign en            = ~vld[LAT-1] | m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_axis_tvalid};
    end
  end

  // alpha and end marker ride alongside
  logic [7:0] alpha_d [LAT];
  logic       last_d  [LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      alpha_d[0] <= s_axis_tdata[31:24];
      last_d[0]  <= s_axis_tlast;
      for (int i = 1; i < LAT; i++) begin
        alpha_d[i] <= alpha_d[i-1];
        last_d[i]  <= last_d[i-1];
      end
    end
  end

  // ---------------------------------------------------------------- channel mapping
  cbpm_pkg::fix_t xo [3];
  cbpm_pkg::fix_t xm [3];

  cbpm_map u_map_r (.clk, .en, .v(s_axis_tdata[7:0]),   .levels(red_levels),
                    .x_orig(xo[0]), .x_map(xm[0]));
  cbpm_map u_map_g (.clk, .en, .v(s_axis_tdata[15:8]),  .levels(green_levels),
                    .x_orig(xo[1]), .x_map(xm[1]));
  cbpm_map u_map_b (.clk, .en, .v(s_axis_tdata[23:16]), .levels(blue_levels),
                    .x_orig(xo[2]), .x_map(xm[2]));

  // mapped values without lightness keeping
  logic [XW-1:0] byp [3][BD];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        byp[c][0] <= xm[c];
        for (int i = 1; i < BD; i++) byp[c][i] <= byp[c][i-1];
      end
    end
  end

  // ---------------------------------------------------------------- lightness keeping
  // stage h: max/min of mapped values, max+min of the original values
  logic [XW-1:0]  mx_o, mn_o, mx_m, mn_m;
  logic [XW-1:0]  hi_h, lo_h, c_h [3];
  logic [L2W-1:0] l2_h;

  always_comb begin
    mx_o = (xo[0] > xo[1]) ? xo[0] : xo[1];
    mx_o = (mx_o > xo[2]) ? mx_o : xo[2];
    mn_o = (xo[0] < xo[1]) ? xo[0] : xo[1];
    mn_o = (mn_o < xo[2]) ? mn_o : xo[2];
    mx_m = (xm[0] > xm[1]) ? xm[0] : xm[1];
    mx_m = (mx_m > xm[2]) ? mx_m : xm[2];
    mn_m = (xm[0] < xm[1]) ? xm[0] : xm[1];
    mn_m = (mn_m < xm[2]) ? mn_m : xm[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hi_h <= mx_m;
      lo_h <= mn_m;
      l2_h <= L2W'(mx_o) + L2W'(mn_o);
      for (int c = 0; c < 3; c++) c_h[c] <= xm[c];
    end
  end

  // stage i: saturation denominators and channel offsets
  logic [L2W-1:0]        sm_i, ad_i, ae_i;
  logic [XW-1:0]         dd_i, ee_i;
  logic [L2W-1:0]        l2_i;
  logic signed [DFW-1:0] dc_i [3];

  always_comb begin
    sm_i = L2W'(hi_h) + L2W'(lo_h);
    ad_i = (sm_i >= ONE2) ? sm_i - ONE2 : ONE2 - sm_i;
    ae_i = (l2_h >= ONE2) ? l2_h - ONE2 : ONE2 - l2_h;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dd_i <= XW'(ONE2 - ad_i);
      ee_i <= XW'(ONE2 - ae_i);
      l2_i <= l2_h;
      for (int c = 0; c < 3; c++)
        dc_i[c] <= $signed((DFW'(c_h[c]) << 1) - DFW'(hi_h) - DFW'(lo_h));
    end
  end

  // stage j: products
  logic [NW-1:0]        pl_j;
  logic signed [NW-1:0] pe_j [3];
  logic [XW-1:0]        dd_j;
  logic [L2W-1:0]       l2_j;
  logic signed [XW:0]   ee_s;

  assign ee_s = $signed({1'b0, ee_i});

  always_ff @(posedge clk) begin
    if (en) begin
      pl_j <= NW'(l2_i) * NW'(dd_i);
      dd_j <= dd_i;
      l2_j <= l2_i;
      for (int c = 0; c < 3; c++) pe_j[c] <= ee_s * dc_i[c];
    end
  end

  // stage k: numerator, rounding offset, sign
  logic signed [NW-1:0] num_k [3];
  logic [NW-1:0]        np_k [3];
  logic                 neg_k [3];
  logic [DENW-1:0]      den_k;
  logic                 dz_k;
  logic [L2W-1:0]       l2_k;

  always_comb begin
    for (int c = 0; c < 3; c++) num_k[c] = $signed(pl_j) + pe_j[c];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        np_k[c]  <= (NW'(num_k[c]) << 1) + NW'(dd_j);
        neg_k[c] <= num_k[c] < 0;
      end
      den_k <= DENW'(dd_j) << 1;
      dz_k  <= dd_j == '0;
      l2_k  <= l2_j;
    end
  end

  // stage l: quotient range check, then divider input
  typedef struct packed {
    logic           dz;
    logic [2:0]     neg;
    logic [2:0]     ovf;
    logic [L2W-1:0] l2;
  } lflag_t;

  cbpm_pkg::div_in_t din [3];
  lflag_t            fl [QW+1];
  logic [NW-1:0]     den_top;

  assign den_top = NW'(den_k) << QW;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        din[c].rem <= np_k[c];
        din[c].den <= den_k;
        fl[0].neg[c] <= neg_k[c];
        fl[0].ovf[c] <= np_k[c] >= den_top;
      end
      fl[0].dz <= dz_k;
      fl[0].l2 <= l2_k;
      for (int i = 1; i <= QW; i++) fl[i] <= fl[i-1];
    end
  end

  logic [QW-1:0] quot [3];

  for (genvar c = 0; c < 3; c++) begin : g_div
    cbpm_div u_div (.clk, .en, .din(din[c]), .quot(quot[c]));
  end

  // ---------------------------------------------------------------- output stage
  logic [XW-1:0]   res  [3];
  logic [XW+7:0]   sc   [3];
  logic [7:0]      byte_o [3];
  logic [L2W-1:0]  half;

  assign half = (fl[QW].l2 + L2W'(1)) >> 1;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (!keep_lightness) begin
        res[c] = byp[c][BD-1];
      end else if (fl[QW].dz) begin
        res[c] = XW'(half);               // grey mapped colour
      end else if (fl[QW].neg[c]) begin
        res[c] = '0;
      end else if (fl[QW].ovf[c] || quot[c] > QW'(cbpm_pkg::ONE)) begin
        res[c] = cbpm_pkg::ONE;
      end else begin
        res[c] = XW'(quot[c]);
      end
      // x * 255 rounded back to 8 bits
      sc[c]     = ({res[c], 8'd0} - (XW+8)'(res[c])) + (XW+8)'(1 << (F - 1));
      byte_o[c] = sc[c][F+7:F];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {alpha_d[LAT-2], byte_o[2], byte_o[1], byte_o[0]};
      m_axis_tlast <= last_d[LAT-2];
    end
  end

  assign m_axis_tvalid = vld[LAT-1];

`ifndef SYNTH
  a_hold: assert property (@(posedge clk) disable iff (rst) !en |=> $stable(vld))
    else $error("pipe moved while stalled");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input held without output stall");
  a_feed: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(vld[LAT-2]))
    else $error("output beat without a pixel in the last stage");
`endif

endmodule

// ===== sim/balance_checker.sv =====
`timescale 1ns / 100ps

module balance_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  output int          fail_count,
  output int          pending_pixels
);

  typedef struct packed {
    logic       last;
    logic [31:0] data;
  } pixel_beat_t;

  logic [47:0] red_lv, green_lv, blue_lv;
  logic        keep_l;
  pixel_beat_t balanced_q[$];

  function automatic longint rnd_shift(longint x, int n);
    longint t;
    t = x + (longint'(1) << (n - 1));
    return t >>> n;
  endfunction

  function automatic longint div_half_up(longint num, longint den);
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic longint clamp1(longint x);
    longint one;
    one = longint'(1) << cbpm_pkg::FRAC_BITS;
    if (x < 0) return 0;
    if (x > one) return one;
    return x;
  endfunction

  function automatic longint unit_of(longint v);
    return div_half_up(v << cbpm_pkg::FRAC_BITS, 255);
  endfunction

  function automatic longint balance_channel(longint v, logic [47:0] lv);
    longint one, x, low, d, mid, s, m, h, w;
    one = longint'(1) << cbpm_pkg::FRAC_BITS;
    x = unit_of(v);
    low = div_half_up((1075 * v + 306000) << cbpm_pkg::FRAC_BITS, 1000 * v + 4080000);
    d = 2 * v - 255;
    mid = div_half_up((667 * (260100 - d * d)) << cbpm_pkg::FRAC_BITS, 260100000);
    s = longint'($signed(lv[15:0]));
    m = longint'($signed(lv[31:16]));
    h = longint'($signed(lv[47:32]));
    w = (s > 0) ? one + low : one - low;
    x = clamp1(x + rnd_shift(s * w, 14));
    x = clamp1(x + rnd_shift(m * mid, 14));
    w = (h > 0) ? one - low : one + low;
    x = clamp1(x + rnd_shift(h * w, 14));
    return x;
  endfunction

  function automatic longint relit(longint c, longint hi, longint lo, longint l2,
                                   longint dd, longint ee);
    longint num;
    if (dd == 0) return clamp1(rnd_shift(l2, 1));
    num = l2 * dd + ee * (2 * c - hi - lo);
    if (num < 0) return 0;
    return clamp1(div_half_up(num, dd));
  endfunction

  function automatic logic [7:0] byte_of(longint x);
    longint v;
    v = clamp1(x) * 255;
    return 8'((v + (longint'(1) << (cbpm_pkg::FRAC_BITS - 1))) >> cbpm_pkg::FRAC_BITS);
  endfunction

  function automatic longint max3(longint a, longint b, longint c);
    longint r;
    r = a > b ? a : b;
    return r > c ? r : c;
  endfunction

  function automatic longint min3(longint a, longint b, longint c);
    longint r;
    r = a < b ? a : b;
    return r < c ? r : c;
  endfunction

  function automatic pixel_beat_t balance_pixel(logic [31:0] d, logic last);
    longint r, g, b, rn, gn, bn, l2, hi, lo, dd, ee, one, r2, g2, b2;
    pixel_beat_t o;
    one = longint'(1) << cbpm_pkg::FRAC_BITS;
    r = d[7:0]; g = d[15:8]; b = d[23:16];
    rn = balance_channel(r, red_lv);
    gn = balance_channel(g, green_lv);
    bn = balance_channel(b, blue_lv);
    if (keep_l) begin
      l2 = max3(unit_of(r), unit_of(g), unit_of(b)) + min3(unit_of(r), unit_of(g), unit_of(b));
      hi = max3(rn, gn, bn);
      lo = min3(rn, gn, bn);
      dd = one - ((hi + lo - one) < 0 ? -(hi + lo - one) : (hi + lo - one));
      ee = one - ((l2 - one) < 0 ? -(l2 - one) : (l2 - one));
      r2 = relit(rn, hi, lo, l2, dd, ee);
      g2 = relit(gn, hi, lo, l2, dd, ee);
      b2 = relit(bn, hi, lo, l2, dd, ee);
      rn = r2; gn = g2; bn = b2;
    end
    o.data = {d[31:24], byte_of(bn), byte_of(gn), byte_of(rn)};
    o.last = last;
    return o;
  endfunction

  assign pending_pixels = balanced_q.size();

  always @(posedge clk) begin
    pixel_beat_t want;
    if (rst) begin
      red_lv <= '0; green_lv <= '0; blue_lv <= '0; keep_l <= 1'b0;
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cbpm_pkg::reg_idx_t'(cfg_index))
          cbpm_pkg::REG_RED:   red_lv <= cfg_data;
          cbpm_pkg::REG_GREEN: green_lv <= cfg_data;
          cbpm_pkg::REG_BLUE:  blue_lv <= cfg_data;
          cbpm_pkg::REG_KEEP:  keep_l <= cfg_data[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        balanced_q.push_back(balance_pixel(s_axis_tdata, s_axis_tlast));
      if (m_axis_tvalid && m_axis_tready) begin
        if (balanced_q.size() == 0) begin
          $display("%0t: unexpected beat %h last %b", $time, m_axis_tdata, m_axis_tlast);
          fail_count <= fail_count + 1;
        end else begin
          want = balanced_q.pop_front();
          if (want.data !== m_axis_tdata || want.last !== m_axis_tlast) begin
            $display("%0t: expected %h last %b, got %h last %b", $time,
                     want.data, want.last, m_axis_tdata, m_axis_tlast);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;

  int fail_count, pending_pixels;
  int idle_cycles = 0;
  bit calm_tail = 0;       // no idling in the last part of the run

  always #5 clk = ~clk;

  color_balance_pixel_map uut (.*);

  balance_checker chk (.*);

  // watchdog: cycles with no beat on any channel
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles > 2000) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // sink side: random stall bursts
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (!calm_tail && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        n = $urandom_range(1, 17);
        repeat (n) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      n = $urandom_range(1, 20);
      repeat (n) @(posedge clk);
    end
  end

  task automatic write_reg(cbpm_pkg::reg_idx_t idx, logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one pixel beat; gap decided before raising valid so valid never drops while a beat waits for ready
  task automatic send_pixel(logic [31:0] px, logic last);
    int n;
    if (!calm_tail && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      n = $urandom_range(1, 17);
      repeat (n) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // let the checker take the last accepted beat first, so it is already counted as pending
  task automatic drain_pipe();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pixels != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(16'sd0 - 16'($urandom_range(1, 4000)));
      4: return 16'($urandom_range(1, 4000));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [47:0] pick_levels();
    return {pick_coef(), pick_coef(), pick_coef()};
  endfunction

  function automatic logic [7:0] pick_level8();
    case ($urandom_range(0, 4))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    logic [7:0] v;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset levels, extremes, greys, red alone and green alone
    for (int k = 0; k < 8; k++) begin
      v = (k == 0) ? 8'h00 : (k == 1) ? 8'hff : (k == 2) ? 8'h80 : 8'($urandom);
      send_pixel({v, v, v, v}, k[0]);
    end
    send_pixel(32'h00_00_00_ff, 1'b0);
    send_pixel(32'hff_00_ff_00, 1'b1);
    drain_pipe();

    write_reg(cbpm_pkg::REG_RED, {16'h8000, 16'h7fff, 16'h8000});
    write_reg(cbpm_pkg::REG_GREEN, {16'h7fff, 16'h8000, 16'h7fff});
    write_reg(cbpm_pkg::REG_BLUE, {16'h1000, 16'h0000, 16'hf000});
    write_reg(cbpm_pkg::REG_KEEP, 48'h1);
    send_pixel(32'h00000000, 1'b0);
    send_pixel(32'hffffffff, 1'b1);
    send_pixel(32'h55_40_40_40, 1'b0);   // grey input
    send_pixel(32'haa_00_80_ff, 1'b0);
    send_pixel(32'h12_ff_00_80, 1'b1);
    drain_pipe();
    write_reg(cbpm_pkg::REG_RED, 48'h0);
    write_reg(cbpm_pkg::REG_GREEN, 48'h0);
    write_reg(cbpm_pkg::REG_BLUE, 48'h0);
    send_pixel(32'h77_10_20_30, 1'b0);   // zero coefficients with lightness keeping
    send_pixel(32'h01_c0_80_40, 1'b1);
    drain_pipe();

    // random phases, each under its own setting
    for (int ph = 0; ph < 13; ph++) begin
      write_reg(cbpm_pkg::REG_RED, pick_levels());
      write_reg(cbpm_pkg::REG_GREEN, pick_levels());
      write_reg(cbpm_pkg::REG_BLUE, pick_levels());
      write_reg(cbpm_pkg::REG_KEEP, {47'($urandom), 1'($urandom)});
      if (ph == 11) calm_tail = 1;
      for (int i = 0; i < 150; i++)
        send_pixel({8'($urandom), pick_level8(), pick_level8(), pick_level8()},
                   ($urandom_range(0, 15) == 0));
      drain_pipe();
    end

    if (fail_count == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
